// ----- hw/rtl/dht22_pkg.sv -----
package dht22_pkg;

    localparam int NUM_PULSES  = 41;
    localparam int DATA_BITS   = 40;
    localparam int TIMER_WIDTH = 16;
    localparam int CNT_W       = $clog2(NUM_PULSES + 1);
    localparam int EDGE_W      = 16;
    localparam int THR_W       = 16;
    localparam int BAD_W       = 8;
    localparam int WORD_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd37;
    localparam logic [BAD_W-1:0] MAX_BAD_RESET   = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAD   = 8'd1;

    typedef enum logic [1:0] {
        MODE_ARM    = 2'd0,
        MODE_EDGE   = 2'd1,
        MODE_FINISH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOLERATED = 2'd1,
        STAT_REPORTED  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        mode;
        logic              level;
        logic [EDGE_W-1:0] edge_time;
    } t_item;

    typedef struct packed {
        logic                 count_full;
        logic                 start_ok;
        logic [DATA_BITS-1:0] bits;
    } t_frame;

endpackage

// ----- hw/rtl/dht22_pulse_frame_decoder_unit.sv -----
// A finish request passes from the input register, where it may wait, to the
// result register. Arm and edge requests give no result.
// Throughput: one request per cycle; only a finish waits, and only while the
// result register is full and not taken.
// Reset: synchronous, active low; capture closed, held values and failure count
// zero, threshold 37, bad-reading limit 2.
module dht22_pulse_frame_decoder_unit #(
    parameter int TIMER_WIDTH = dht22_pkg::TIMER_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic                                i_line_level,
    input  logic [dht22_pkg::EDGE_W-1:0]        i_edge_time,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [dht22_pkg::WORD_W-1:0]        o_humidity_tenths,
    output logic signed [dht22_pkg::WORD_W-1:0] o_temperature_tenths,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dht22_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dht22_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dht22_pkg::*;

    logic             r_in_valid;
    t_item            r_item;
    logic [THR_W-1:0] r_threshold;
    logic [BAD_W-1:0] r_max_bad;

    logic   out_free;
    logic   fire;
    logic   is_finish;
    t_frame frame;

    assign is_finish  = (t_mode'(r_item.mode) == MODE_FINISH);
    assign fire       = r_in_valid && (!is_finish || out_free);
    assign o_in_ready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.mode      <= i_mode;
            r_item.level     <= i_line_level;
            r_item.edge_time <= i_edge_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_max_bad   <= MAX_BAD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data[THR_W-1:0];
            end else if (i_cfg_index == CFG_MAX_BAD) begin
                r_max_bad <= i_cfg_data[BAD_W-1:0];
            end
        end
    end

    dht22_capture #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_item),
        .i_threshold(r_threshold),
        .o_frame    (frame)
    );

    dht22_decode u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire_finish       (fire && is_finish),
        .i_frame             (frame),
        .i_max_bad           (r_max_bad),
        .o_out_free          (out_free),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_humidity_tenths   (o_humidity_tenths),
        .o_temperature_tenths(o_temperature_tenths)
    );

endmodule

// ----- hw/rtl/dht22_capture.sv -----
module dht22_capture #(
    parameter int TIMER_WIDTH = dht22_pkg::TIMER_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  dht22_pkg::t_item              i_item,
    input  logic [dht22_pkg::THR_W-1:0]   i_threshold,
    output dht22_pkg::t_frame             o_frame
);
    import dht22_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > THR_W) ? TIMER_WIDTH : THR_W;

    logic [CNT_W-1:0]       r_count, n_count;
    logic [TIMER_WIDTH-1:0] r_rise, n_rise;
    logic                   r_rise_valid, n_rise_valid;
    logic                   r_start_ok, n_start_ok;
    logic [DATA_BITS-1:0]   r_bits, n_bits;

    logic [TIMER_WIDTH-1:0] now;
    logic [TIMER_WIDTH-1:0] width;
    logic                   is_one;

    assign now    = TIMER_WIDTH'(i_item.edge_time);
    assign width  = now - r_rise;
    assign is_one = CMP_W'(width) >= CMP_W'(i_threshold);

    always_comb begin
        n_count      = r_count;
        n_rise       = r_rise;
        n_rise_valid = r_rise_valid;
        n_start_ok   = r_start_ok;
        n_bits       = r_bits;
        if (i_fire) begin
            case (t_mode'(i_item.mode))
                MODE_ARM: begin
                    n_count      = '0;
                    n_rise       = '0;
                    n_rise_valid = 1'b0;
                    n_start_ok   = 1'b0;
                    n_bits       = '0;
                end
                MODE_EDGE: begin
                    if (r_count < CNT_W'(NUM_PULSES)) begin
                        if (i_item.level) begin
                            n_rise       = now;
                            n_rise_valid = 1'b1;
                        end else if (r_rise_valid) begin
                            if (r_count == '0) begin
                                n_start_ok = is_one;
                            end else begin
                                n_bits = {r_bits[DATA_BITS-2:0], is_one};
                            end
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                MODE_FINISH: begin
                    n_count = CNT_W'(NUM_PULSES);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CNT_W'(NUM_PULSES);
            r_rise       <= '0;
            r_rise_valid <= 1'b0;
            r_start_ok   <= 1'b0;
            r_bits       <= '0;
        end else begin
            r_count      <= n_count;
            r_rise       <= n_rise;
            r_rise_valid <= n_rise_valid;
            r_start_ok   <= n_start_ok;
            r_bits       <= n_bits;
        end
    end

    assign o_frame.count_full = (r_count == CNT_W'(NUM_PULSES));
    assign o_frame.start_ok   = r_start_ok;
    assign o_frame.bits       = r_bits;

endmodule

// ----- hw/rtl/dht22_decode.sv -----
module dht22_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire_finish,
    input  dht22_pkg::t_frame              i_frame,
    input  logic [dht22_pkg::BAD_W-1:0]    i_max_bad,
    output logic                           o_out_free,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [dht22_pkg::WORD_W-1:0]   o_humidity_tenths,
    output logic signed [dht22_pkg::WORD_W-1:0] o_temperature_tenths
);
    import dht22_pkg::*;

    logic [BAD_W-1:0]  r_bad, n_bad;
    logic [WORD_W-1:0] r_hum, n_hum;
    logic [WORD_W-1:0] r_temp, n_temp;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_out_hum, n_out_hum;
    logic [WORD_W-1:0] r_out_temp, n_out_temp;

    logic [7:0]        b0, b1, b2, b3, b4, sum;
    logic              good;
    logic [14:0]       mag;
    logic [WORD_W-1:0] temp_word;

    assign b0  = i_frame.bits[39:32];
    assign b1  = i_frame.bits[31:24];
    assign b2  = i_frame.bits[23:16];
    assign b3  = i_frame.bits[15:8];
    assign b4  = i_frame.bits[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign good = i_frame.count_full && i_frame.start_ok && (sum == b4);
    assign mag  = {b2[6:0], b3};
    assign temp_word = b2[7] ? (WORD_W'(0) - {1'b0, mag}) : {1'b0, mag};

    assign o_out_free = !r_valid || i_out_ready;

    always_comb begin
        n_bad      = r_bad;
        n_hum      = r_hum;
        n_temp     = r_temp;
        n_valid    = r_valid && !i_out_ready;
        n_status   = r_status;
        n_out_hum  = r_out_hum;
        n_out_temp = r_out_temp;
        if (i_fire_finish) begin
            n_valid = 1'b1;
            if (good) begin
                n_hum      = {b0, b1};
                n_temp     = temp_word;
                n_bad      = '0;
                n_status   = STAT_OK;
                n_out_hum  = {b0, b1};
                n_out_temp = temp_word;
            end else if (r_bad < i_max_bad) begin
                n_bad      = r_bad + BAD_W'(1);
                n_status   = STAT_TOLERATED;
                n_out_hum  = r_hum;
                n_out_temp = r_temp;
            end else begin
                n_status   = STAT_REPORTED;
                n_out_hum  = '0;
                n_out_temp = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad   <= '0;
            r_hum   <= '0;
            r_temp  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_bad   <= n_bad;
            r_hum   <= n_hum;
            r_temp  <= n_temp;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_hum  <= n_out_hum;
        r_out_temp <= n_out_temp;
    end

    assign o_out_valid          = r_valid;
    assign o_status             = r_status;
    assign o_humidity_tenths    = r_out_hum;
    assign o_temperature_tenths = r_out_temp;

endmodule

// ----- hw/rtl/dht22_checker.sv -----
module dht22_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_mode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_humidity_tenths,
    input logic [15:0] o_temperature_tenths
);
    import dht22_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_humidity_tenths) && $stable(o_temperature_tenths))
        else $error("stalled result changed");

    a_reported_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_REPORTED) |->
            (o_humidity_tenths == '0) && (o_temperature_tenths == '0))
        else $error("reported failure carries data");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_mode == MODE_FINISH), 2))
        else $error("result without finish request");

endmodule

bind dht22_pulse_frame_decoder_unit dht22_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .i_mode              (i_mode),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_status            (o_status),
    .o_humidity_tenths   (o_humidity_tenths),
    .o_temperature_tenths(o_temperature_tenths)
);

// ----- sim/tb.sv -----
module tb;
    import dht22_pkg::*;

    localparam logic [1:0]           MODE_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 8'hFF;
    localparam int                   STALL_LIMIT   = 4000;
    localparam int                   HOLD_OFF      = 300;
    localparam int                   LINGER        = 6;
    localparam int                   PHASE_ITEMS   = 225;
    localparam int                   PHASE_READS   = 8;
    localparam int                   SCRIPT_LEN    = 17;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   hum;
        logic [WORD_W-1:0]   temp;
    } t_reading;

    typedef struct {
        logic [1:0]        mode;
        logic              lvl;
        logic [EDGE_W-1:0] stamp;
        bit                pinned;
        t_reading          want;
    } t_script_row;

    localparam t_reading NO_PIN        = '0;
    localparam t_reading KEPT_ZERO     = '{STAT_TOLERATED, 16'd0, 16'd0};
    localparam t_reading REPORTED_ZERO = '{STAT_REPORTED, 16'd0, 16'd0};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [1:0]                  i_mode;
    logic                        i_line_level;
    logic [EDGE_W-1:0]           i_edge_time;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  o_status;
    logic [WORD_W-1:0]           o_humidity_tenths;
    logic signed [WORD_W-1:0]    o_temperature_tenths;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    dht22_pulse_frame_decoder_unit i_dut (.*);

    logic [THR_W-1:0]     thr_ticks;
    logic [BAD_W-1:0]     bad_limit;
    int                   pulses_taken;
    logic [EDGE_W-1:0]    rise_stamp;
    bit                   rise_seen;
    bit                   start_bit;
    logic [DATA_BITS-1:0] frame_word;
    logic [BAD_W-1:0]     fail_run;
    logic [WORD_W-1:0]    held_hum;
    logic [WORD_W-1:0]    held_temp;

    t_reading          readings_due[$];
    t_reading          head;
    t_script_row       script[SCRIPT_LEN];
    logic [EDGE_W-1:0] line_clock;
    int                mismatches;
    int                effective_items;
    int                finishes_sent;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                hold_ticket;
    int                hold_served;
    int                hold_left;
    int                quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit decode_request(input logic [1:0] m, input logic lvl,
                                          input logic [EDGE_W-1:0] stamp,
                                          output bit has_reading, output t_reading r);
        logic [EDGE_W-1:0] width;
        logic [7:0]        sum;
        logic [14:0]       mag;
        bit                one;
        has_reading = 1'b0;
        r = '0;
        case (m)
            MODE_ARM: begin
                pulses_taken = 0;
                rise_stamp = '0;
                rise_seen = 1'b0;
                start_bit = 1'b0;
                frame_word = '0;
                return 1'b1;
            end
            MODE_EDGE: begin
                if (pulses_taken < NUM_PULSES) begin
                    if (lvl) begin
                        rise_stamp = stamp;
                        rise_seen = 1'b1;
                        return 1'b1;
                    end else if (rise_seen) begin
                        width = stamp - rise_stamp;
                        one = (width >= thr_ticks);
                        if (pulses_taken == 0)
                            start_bit = one;
                        else
                            frame_word = {frame_word[DATA_BITS-2:0], one};
                        pulses_taken++;
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            MODE_FINISH: begin
                sum = frame_word[39:32] + frame_word[31:24] + frame_word[23:16]
                    + frame_word[15:8];
                if (pulses_taken == NUM_PULSES && start_bit && sum == frame_word[7:0]) begin
                    mag = {frame_word[22:16], frame_word[15:8]};
                    held_hum = frame_word[39:24];
                    held_temp = frame_word[23] ? WORD_W'(0) - WORD_W'(mag) : WORD_W'(mag);
                    fail_run = '0;
                    r = '{STAT_OK, held_hum, held_temp};
                end else if (fail_run < bad_limit) begin
                    fail_run++;
                    r = '{STAT_TOLERATED, held_hum, held_temp};
                end else begin
                    r = REPORTED_ZERO;
                end
                pulses_taken = NUM_PULSES;
                has_reading = 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_request(input logic [1:0] m, input logic lvl,
                                input logic [EDGE_W-1:0] stamp,
                                input bit pinned = 1'b0, input t_reading pin = NO_PIN);
        int       gap;
        bit       has_reading;
        t_reading r;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_line_level <= lvl;
        i_edge_time <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_request(m, lvl, stamp, has_reading, r)) effective_items++;
        if (has_reading) begin
            readings_due.push_back(pinned ? pin : r);
            finishes_sent++;
        end
    endtask

    task automatic drain_readings(input int linger);
        i_in_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (linger) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_THRESHOLD)
            thr_ticks = val[THR_W-1:0];
        else if (idx == CFG_MAX_BAD)
            bad_limit = val[BAD_W-1:0];
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] thr_val,
                                     input logic [CFG_DATA_W-1:0] bad_val,
                                     input bit spare);
        write_register(CFG_THRESHOLD, thr_val);
        if (spare) write_register(CFG_SPARE, 16'($urandom()));
        write_register(CFG_MAX_BAD, bad_val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [EDGE_W-1:0] pulse_width(input bit one);
        int thr;
        int span;
        thr = int'(thr_ticks);
        if (one) begin
            span = 65535 - thr;
            if (span > 40) span = 40;
            return EDGE_W'(thr + $urandom_range(span, 0));
        end
        span = thr - 1;
        if (span > 40 && $urandom_range(1) == 1)
            return EDGE_W'(span - $urandom_range(40, 0));
        return EDGE_W'($urandom_range(span, 0));
    endfunction

    task automatic send_pulse(input logic [EDGE_W-1:0] width);
        line_clock = line_clock + EDGE_W'($urandom_range(80, 1));
        push_request(MODE_EDGE, 1'b1, line_clock);
        line_clock = line_clock + width;
        push_request(MODE_EDGE, 1'b0, line_clock);
    endtask

    task automatic send_frame();
        logic [DATA_BITS-1:0] bits;
        logic [7:0]           sum;
        bits = {32'($urandom()), 8'h00};
        sum = bits[39:32] + bits[31:24] + bits[23:16] + bits[15:8];
        bits[7:0] = ($urandom_range(9) == 0) ? sum ^ 8'($urandom_range(255, 1)) : sum;
        push_request(MODE_ARM, 1'($urandom_range(1)), 16'($urandom()));
        if ($urandom_range(7) == 0) push_request(MODE_EDGE, 1'b0, 16'($urandom()));
        send_pulse(pulse_width($urandom_range(9) != 0));
        for (int i = DATA_BITS - 1; i >= 0; i--) send_pulse(pulse_width(bits[i]));
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) send_pulse(pulse_width(1'($urandom_range(1))));
        push_request(MODE_FINISH, 1'($urandom_range(1)), 16'($urandom()));
    endtask

    task automatic send_torn_frame();
        int pick;
        push_request(MODE_ARM, 1'($urandom_range(1)), 16'($urandom()));
        repeat ($urandom_range(45, 0)) begin
            pick = $urandom_range(7);
            if (pick < 6)
                send_pulse(pulse_width(1'($urandom_range(1))));
            else
                push_request(MODE_EDGE, 1'(pick == 6), 16'($urandom()));
        end
        push_request(MODE_FINISH, 1'($urandom_range(1)), 16'($urandom()));
    endtask

    task automatic run_phase(input bit squeeze);
        int item_mark;
        int read_mark;
        int pick;
        item_mark = effective_items;
        read_mark = finishes_sent;
        if (squeeze) begin
            hold_ticket++;
            repeat (8) push_request(MODE_FINISH, 1'($urandom_range(1)), 16'($urandom()));
            drain_readings(0);
        end
        while (effective_items - item_mark < PHASE_ITEMS
               || finishes_sent - read_mark < PHASE_READS) begin
            pick = $urandom_range(19);
            if (pick < 8)
                send_frame();
            else if (pick < 13)
                send_torn_frame();
            else if (pick < 15)
                repeat ($urandom_range(8, 1))
                    push_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                                 16'($urandom()));
            else
                repeat ($urandom_range(4, 1))
                    push_request(MODE_FINISH, 1'($urandom_range(1)), 16'($urandom()));
        end
        drain_readings(LINGER);
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (readings_due.size() == 0) begin
                mismatches++;
                $error("reading with none pending: status %0d humidity %0d temperature %0d",
                       o_status, o_humidity_tenths, o_temperature_tenths);
            end else begin
                head = readings_due.pop_front();
                if (o_status !== head.status) begin
                    mismatches++;
                    $error("status: expected %0d, got %0d", head.status, o_status);
                end
                if (o_humidity_tenths !== head.hum) begin
                    mismatches++;
                    $error("humidity_tenths: expected %0d, got %0d", head.hum,
                           o_humidity_tenths);
                end
                if (o_temperature_tenths !== head.temp) begin
                    mismatches++;
                    $error("temperature_tenths: expected %0d, got %0d",
                           $signed(head.temp), o_temperature_tenths);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        script = '{
            '{MODE_FINISH, 1'b0, 16'h0000, 1'b1, KEPT_ZERO},
            '{MODE_FINISH, 1'b1, 16'hFFFF, 1'b1, KEPT_ZERO},
            '{MODE_FINISH, 1'b0, 16'h8000, 1'b1, REPORTED_ZERO},
            '{MODE_SPARE,  1'b1, 16'hFFFF, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b1, 16'h0000, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b0, 16'hFFFF, 1'b0, NO_PIN},
            '{MODE_ARM,    1'b1, 16'hFFFF, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b0, 16'h1234, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b1, 16'hFFF0, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b0, 16'h0014, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b1, 16'h0000, 1'b0, NO_PIN},
            '{MODE_EDGE,   1'b0, 16'h0025, 1'b0, NO_PIN},
            '{MODE_SPARE,  1'b0, 16'h0000, 1'b0, NO_PIN},
            '{MODE_FINISH, 1'b1, 16'h5555, 1'b1, REPORTED_ZERO},
            '{MODE_EDGE,   1'b1, 16'h0100, 1'b0, NO_PIN},
            '{MODE_ARM,    1'b0, 16'h0000, 1'b0, NO_PIN},
            '{MODE_FINISH, 1'b0, 16'hAAAA, 1'b1, REPORTED_ZERO}
        };
        mismatches = 0;
        effective_items = 0;
        finishes_sent = 0;
        hold_ticket = 0;
        hold_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        line_clock = '0;
        thr_ticks = THRESHOLD_RESET;
        bad_limit = MAX_BAD_RESET;
        pulses_taken = NUM_PULSES;
        rise_stamp = '0;
        rise_seen = 1'b0;
        start_bit = 1'b0;
        frame_word = '0;
        fail_run = '0;
        held_hum = '0;
        held_temp = '0;
        tx_idle_pct = 28;
        rx_idle_pct = 74;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_ARM;
        i_line_level <= 1'b0;
        i_edge_time <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            push_request(script[i].mode, script[i].lvl, script[i].stamp,
                         script[i].pinned, script[i].want);
        drain_readings(LINGER);

        program_registers(16'd1, 16'd0, 1'b0);
        run_phase(1'b0);

        tx_idle_pct = 74;
        rx_idle_pct = 28;
        program_registers(16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_registers(16'd37, 16'd3, 1'b1);
        run_phase(1'b1);

        program_registers(16'($urandom_range(600, 2)), 16'($urandom_range(6, 1)), 1'b0);
        run_phase(1'b0);

        drain_readings(LINGER);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
